[hdl/rad_pkg.sv]
package rad_pkg;

  localparam int unsigned NUMERIC_BLOCK_MAX = 1000;
  localparam int unsigned CHAR_BLOCK_MAX    = 105;

  localparam logic [31:0] MARKER_LEN = 32'd16;
  localparam logic [31:0] LOGI_TRUE  = 32'hffff_ffff;
  localparam logic [31:0] LOGI_FALSE = 32'h0000_0000;

  typedef enum logic [4:0] {
    PH_HUNT     = 5'b00001,
    PH_HEADER   = 5'b00010,
    PH_REC_HEAD = 5'b00100,
    PH_ELEMS    = 5'b01000,
    PH_REC_TAIL = 5'b10000
  } phase_e;

  typedef enum logic [2:0] {
    T_INTE    = 3'd0,
    T_REAL    = 3'd1,
    T_DOUB    = 3'd2,
    T_LOGI    = 3'd3,
    T_CHAR    = 3'd4,
    T_MESS    = 3'd5,
    T_UNKNOWN = 3'd7
  } type_e;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_ELEMENT = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_MARKER  = 3'd0,
    ERR_TYPE    = 3'd1,
    ERR_MESSAGE = 3'd2,
    ERR_LENGTH  = 3'd3,
    ERR_COUNT   = 3'd4,
    ERR_TAIL    = 3'd5,
    ERR_LOGICAL = 3'd6
  } err_e;

  localparam logic [31:0] WORD_INTE = 32'h494E5445;
  localparam logic [31:0] WORD_REAL = 32'h5245414C;
  localparam logic [31:0] WORD_DOUB = 32'h444F5542;
  localparam logic [31:0] WORD_LOGI = 32'h4C4F4749;
  localparam logic [31:0] WORD_CHAR = 32'h43484152;
  localparam logic [31:0] WORD_MESS = 32'h4D455353;

  function automatic type_e type_decode(input logic [31:0] w);
    type_e t;
    case (w)
      WORD_INTE: t = T_INTE;
      WORD_REAL: t = T_REAL;
      WORD_DOUB: t = T_DOUB;
      WORD_LOGI: t = T_LOGI;
      WORD_CHAR: t = T_CHAR;
      WORD_MESS: t = T_MESS;
      default:   t = T_UNKNOWN;
    endcase
    return t;
  endfunction

endpackage

[hdl/record_array_deframer.sv]
// an accepted word is held in the input register; its result is then registered in the result register
// throughput: one word per cycle while the result register is not stalled; the header, length and element checks all
// run in the single stage between the input register and the result register
// a stalled result holds the result register, the input register still takes one word
// reset (rst_ni low, asynchronous) empties both registers and expects a header marker as the first word
module record_array_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [63:0] value_o,
  output logic [2:0]  type_code_o,
  output logic signed [31:0] element_count_o,
  output logic [2:0]  error_code_o,
  output logic        last_element_o
);

  // input register
  logic        word_valid_q;
  logic [31:0] word_q;

  // block state
  rad_pkg::phase_e phase_q, phase_d;
  logic [2:0]      hpos_q, hpos_d;
  logic [63:0]     name_q, name_d;
  rad_pkg::type_e  type_q, type_d;
  logic [31:0]     remain_q, remain_d;
  logic [31:0]     rec_len_q, rec_len_d;
  logic [10:0]     rec_left_q, rec_left_d;
  logic [31:0]     upper_q, upper_d;

  // result register
  logic        res_valid_q;
  logic [1:0]  kind_q, kind_d;
  logic [63:0] value_q, value_d;
  logic [2:0]  rtype_q, rtype_d;
  logic [31:0] count_q, count_d;
  logic [2:0]  err_q, err_d;
  logic        last_q, last_d;
  logic        emit;

  logic        advance;
  logic        in_accept;
  logic        wide;
  logic        len_bad;
  logic [31:0] num;
  logic [31:0] maxn;
  logic [31:0] remain_dec;
  logic [10:0] rec_left_dec;

  assign advance   = word_valid_q && (!res_valid_q || !out_stall_i);
  assign in_stall_o = word_valid_q && !advance;
  assign in_accept = in_valid_i && !in_stall_o;

  assign wide = (type_q == rad_pkg::T_DOUB) || (type_q == rad_pkg::T_CHAR);
  assign len_bad = word_q[31] || (wide ? (word_q[2:0] != 3'd0) : (word_q[1:0] != 2'd0));
  assign num  = wide ? {3'd0, word_q[31:3]} : {2'd0, word_q[31:2]};
  assign maxn = (type_q == rad_pkg::T_CHAR) ? 32'(rad_pkg::CHAR_BLOCK_MAX)
                                            : 32'(rad_pkg::NUMERIC_BLOCK_MAX);
  assign remain_dec   = remain_q - 32'd1;
  assign rec_left_dec = rec_left_q - 11'd1;

  always_comb begin
    phase_d    = phase_q;
    hpos_d     = hpos_q;
    name_d     = name_q;
    type_d     = type_q;
    remain_d   = remain_q;
    rec_len_d  = rec_len_q;
    rec_left_d = rec_left_q;
    upper_d    = upper_q;
    emit    = 1'b0;
    kind_d  = rad_pkg::KIND_ERROR;
    value_d = 64'd0;
    rtype_d = 3'd0;
    count_d = 32'd0;
    err_d   = rad_pkg::ERR_MARKER;
    last_d  = 1'b0;

    case (phase_q)
      rad_pkg::PH_HUNT: begin
        if (word_q == rad_pkg::MARKER_LEN) begin
          phase_d = rad_pkg::PH_HEADER;
          hpos_d  = 3'd1;
        end
      end
      rad_pkg::PH_HEADER: begin
        case (hpos_q)
          3'd0: begin
            if (word_q != rad_pkg::MARKER_LEN) begin
              emit  = 1'b1;
              err_d = rad_pkg::ERR_MARKER;
            end else begin
              hpos_d = 3'd1;
            end
          end
          3'd1: begin
            name_d = {word_q, 32'd0};
            hpos_d = 3'd2;
          end
          3'd2: begin
            name_d = {name_q[63:32], word_q};
            hpos_d = 3'd3;
          end
          3'd3: begin
            remain_d = word_q;
            hpos_d   = 3'd4;
          end
          3'd4: begin
            type_d = rad_pkg::type_decode(word_q);
            hpos_d = 3'd5;
          end
          default: begin
            if (word_q != rad_pkg::MARKER_LEN) begin
              emit  = 1'b1;
              err_d = rad_pkg::ERR_MARKER;
            end else if (type_q == rad_pkg::T_UNKNOWN) begin
              emit  = 1'b1;
              err_d = rad_pkg::ERR_TYPE;
            end else if (type_q == rad_pkg::T_MESS && remain_q != 32'd0) begin
              emit  = 1'b1;
              err_d = rad_pkg::ERR_MESSAGE;
            end else begin
              emit    = 1'b1;
              kind_d  = rad_pkg::KIND_HEADER;
              value_d = name_q;
              rtype_d = type_q;
              count_d = remain_q;
              err_d   = rad_pkg::ERR_MARKER;
              hpos_d  = 3'd0;
              // empty array, message or negative count: the next word opens a new header
              if (type_q == rad_pkg::T_MESS || remain_q == 32'd0 || remain_q[31]) begin
                remain_d = 32'd0;
                phase_d  = rad_pkg::PH_HEADER;
              end else begin
                phase_d = rad_pkg::PH_REC_HEAD;
              end
            end
          end
        endcase
      end
      rad_pkg::PH_REC_HEAD: begin
        if (len_bad || num > maxn) begin
          emit  = 1'b1;
          err_d = rad_pkg::ERR_LENGTH;
        end else if (num > remain_q || (num < maxn && num != remain_q)) begin
          emit  = 1'b1;
          err_d = rad_pkg::ERR_COUNT;
        end else begin
          rec_len_d  = word_q;
          rec_left_d = num[10:0];
          hpos_d     = 3'd0;
          phase_d    = rad_pkg::PH_ELEMS;
        end
      end
      rad_pkg::PH_ELEMS: begin
        if (wide && hpos_q == 3'd0) begin
          upper_d = word_q;
          hpos_d  = 3'd1;
        end else if (!wide && type_q == rad_pkg::T_LOGI &&
                     word_q != rad_pkg::LOGI_FALSE && word_q != rad_pkg::LOGI_TRUE) begin
          emit  = 1'b1;
          err_d = rad_pkg::ERR_LOGICAL;
        end else begin
          emit       = 1'b1;
          kind_d     = rad_pkg::KIND_ELEMENT;
          value_d    = wide ? {upper_q, word_q} : {32'd0, word_q};
          rtype_d    = type_q;
          last_d     = (remain_dec == 32'd0);
          hpos_d     = 3'd0;
          remain_d   = remain_dec;
          rec_left_d = rec_left_dec;
          if (rec_left_dec == 11'd0) begin
            phase_d = rad_pkg::PH_REC_TAIL;
          end
        end
      end
      rad_pkg::PH_REC_TAIL: begin
        if (word_q != rec_len_q) begin
          emit  = 1'b1;
          err_d = rad_pkg::ERR_TAIL;
        end else begin
          phase_d = (remain_q == 32'd0) ? rad_pkg::PH_HEADER : rad_pkg::PH_REC_HEAD;
          hpos_d  = 3'd0;
        end
      end
      default: begin
        phase_d = rad_pkg::PH_HUNT;
        hpos_d  = 3'd0;
      end
    endcase

    // any error drops back to hunting for a header marker
    if (emit && kind_d == rad_pkg::KIND_ERROR) begin
      phase_d = rad_pkg::PH_HUNT;
      hpos_d  = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_valid_q <= 1'b0;
    end else if (in_accept) begin
      word_valid_q <= 1'b1;
    end else if (advance) begin
      word_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      word_q <= word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= rad_pkg::PH_HEADER;
      hpos_q     <= 3'd0;
      name_q     <= 64'd0;
      type_q     <= rad_pkg::T_INTE;
      remain_q   <= 32'd0;
      rec_len_q  <= 32'd0;
      rec_left_q <= 11'd0;
      upper_q    <= 32'd0;
    end else if (advance) begin
      phase_q    <= phase_d;
      hpos_q     <= hpos_d;
      name_q     <= name_d;
      type_q     <= type_d;
      remain_q   <= remain_d;
      rec_len_q  <= rec_len_d;
      rec_left_q <= rec_left_d;
      upper_q    <= upper_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= emit;
    end else if (!out_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      kind_q  <= kind_d;
      value_q <= value_d;
      rtype_q <= rtype_d;
      count_q <= count_d;
      err_q   <= err_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o     = res_valid_q;
  assign result_kind_o   = kind_q;
  assign value_o         = value_q;
  assign type_code_o     = rtype_q;
  assign element_count_o = count_q;
  assign error_code_o    = err_q;
  assign last_element_o  = last_q;

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == rad_pkg::KIND_ERROR |->
      value_o == 64'd0 && last_element_o == 1'b0 && element_count_o == 32'sd0)
    else $error("error result carries payload bits");

  a_error_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit && kind_d == rad_pkg::KIND_ERROR |=> phase_q == rad_pkg::PH_HUNT)
    else $error("error did not return to header hunt");

  a_last_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit && kind_d == rad_pkg::KIND_ELEMENT && last_d |=>
      phase_q == rad_pkg::PH_REC_TAIL)
    else $error("last element not followed by record tail");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> word_valid_q && res_valid_q && out_stall_i)
    else $error("input stalled with free room");

  a_rec_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == rad_pkg::PH_ELEMS |-> rec_left_q != 11'd0)
    else $error("element phase with empty record");

endmodule
